// ===== hdl/stable_priority_queue_assert.svh =====
// Assertion macros used by the stable priority queue top level.
`ifndef STABLE_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/spq_pkg.sv =====
// Types and constants of the stable priority queue.
`default_nettype none

package spq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned PRIO_W      = 8;
  localparam int unsigned ID_W        = 16;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } spq_status_e;

  typedef enum logic {
    MODE_PUSH = 1'b0,
    MODE_POP  = 1'b1
  } spq_mode_e;

  typedef struct packed {
    logic              mode;
    logic [PRIO_W-1:0] priority_req;
    logic [ID_W-1:0]   process_id;
  } spq_in_t;

  typedef struct packed {
    spq_status_e       status;
    logic [ID_W-1:0]   out_id;
    logic [PRIO_W-1:0] out_priority;
    logic              now_empty;
  } spq_out_t;

  // Broadcast to every cell: what happens this cycle and the entry to insert.
  typedef struct packed {
    logic              push;
    logic              pop;
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
  } spq_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/stable_priority_queue.sv =====
// Top level of the stable priority queue: a row of slot cells and a result register.
//
// Stable priority queue of (priority, process id) entries, smallest priority
// at the head, equal priorities served in arrival order. Each input transfer
// is either a push or a pop and yields exactly one result transfer, which
// carries a status (done, push rejected because full, pop found empty), the
// popped id and priority (zero for a push or a failed pop), and whether the
// queue is empty afterwards. The storage is a row of QueueDepth identical
// cells; every cell compares its entry with the pushed priority in parallel
// and either holds, takes the new entry, or takes its neighbor's entry, so a
// push or a pop completes in a single parallel update. The block accepts one
// transfer per cycle; the result is loaded into an output register on
// acceptance, and input is stalled only while that register holds a result
// that the receiver is stalling. No clearing pass is needed after reset.
`default_nettype none
`include "stable_priority_queue_assert.svh"

module stable_priority_queue #(
  parameter int unsigned QueueDepth = spq_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire spq_pkg::spq_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output spq_pkg::spq_out_t      out_data_o
);

  // Per-cell outputs, read at fixed neighbor positions.
  logic [QueueDepth-1:0]      occ_vec;
  logic [QueueDepth-1:0]      keep_vec;
  logic [spq_pkg::PRIO_W-1:0] prio_arr [QueueDepth];
  logic [spq_pkg::ID_W-1:0]   id_arr   [QueueDepth];

  logic               in_xfer;
  logic               is_pop;
  logic               full;
  logic               empty;
  spq_pkg::spq_ctrl_t ctrl;
  spq_pkg::spq_out_t  result;

  logic              out_valid_q, out_valid_d;
  spq_pkg::spq_out_t out_data_q;

  // Hold input while a finished result waits on a stalled receiver.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign is_pop     = (in_data_i.mode == spq_pkg::MODE_POP);

  // Occupancy is a run of ones from the head, so the ends tell full and empty.
  assign full  = occ_vec[QueueDepth-1];
  assign empty = !occ_vec[0];

  always_comb begin
    ctrl.push = in_xfer && !is_pop && !full;
    ctrl.pop  = in_xfer && is_pop && !empty;
    ctrl.prio = in_data_i.priority_req;
    ctrl.id   = in_data_i.process_id;
  end

  // Cell row: the head cell sees an always-keeping left neighbor so a push
  // behind nothing lands in slot 0; the tail cell sees an empty right neighbor.
  for (genvar g = 0; g < QueueDepth; g++) begin : g_cell
    logic                       l_keep, l_occ, r_occ;
    logic [spq_pkg::PRIO_W-1:0] l_prio, r_prio;
    logic [spq_pkg::ID_W-1:0]   l_id, r_id;

    if (g == 0) begin : g_head
      assign l_keep = 1'b1;
      assign l_occ  = 1'b0;
      assign l_prio = ctrl.prio;
      assign l_id   = ctrl.id;
    end else begin : g_body
      assign l_keep = keep_vec[g-1];
      assign l_occ  = occ_vec[g-1];
      assign l_prio = prio_arr[g-1];
      assign l_id   = id_arr[g-1];
    end

    if (g == QueueDepth - 1) begin : g_tail
      assign r_occ  = 1'b0;
      assign r_prio = prio_arr[g];
      assign r_id   = id_arr[g];
    end else begin : g_inner
      assign r_occ  = occ_vec[g+1];
      assign r_prio = prio_arr[g+1];
      assign r_id   = id_arr[g+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .left_keep_i  (l_keep),
      .left_occ_i   (l_occ),
      .left_prio_i  (l_prio),
      .left_id_i    (l_id),
      .right_occ_i  (r_occ),
      .right_prio_i (r_prio),
      .right_id_i   (r_id),
      .keep_o       (keep_vec[g]),
      .occ_o        (occ_vec[g]),
      .prio_o       (prio_arr[g]),
      .id_o         (id_arr[g])
    );
  end

  // Build the result of the item being transferred this cycle.
  always_comb begin
    result.status       = spq_pkg::STATUS_DONE;
    result.out_id       = '0;
    result.out_priority = '0;
    result.now_empty    = 1'b0;
    if (is_pop) begin
      if (empty) begin
        result.status    = spq_pkg::STATUS_EMPTY;
        result.now_empty = 1'b1;
      end else begin
        result.out_id       = id_arr[0];
        result.out_priority = prio_arr[0];
        result.now_empty    = !occ_vec[1];
      end
    end else if (full) begin
      result.status = spq_pkg::STATUS_FULL;
    end
  end

  // Output register: load on input transfer, hold while stalled, drop when taken.
  assign out_valid_d = in_xfer || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Checks: occupancy contiguous from the head, entries sorted, push grows
  // the queue by one, pop returns the old head.
  logic [QueueDepth-1:0] order_ok;

  always_comb begin
    order_ok = '1;
    for (int unsigned i = 0; i + 1 < QueueDepth; i++) begin
      order_ok[i] = !occ_vec[i+1] || (prio_arr[i] <= prio_arr[i+1]);
    end
  end

  `SPQ_ASSERT_NOW(a_occ_contiguous, 1'b1,
    ((occ_vec + QueueDepth'(1)) & occ_vec) == '0, "slot occupancy has a hole")
  `SPQ_ASSERT_NOW(a_sorted, 1'b1, &order_ok, "queue entries out of priority order")
  `SPQ_ASSERT_NEXT(a_push_grows, ctrl.push,
    $countones(occ_vec) == $countones($past(occ_vec)) + 1, "push did not add one entry")
  `SPQ_ASSERT_NEXT(a_pop_head, ctrl.pop,
    out_valid_q && (out_data_q.out_priority == $past(prio_arr[0]))
      && (out_data_q.out_id == $past(id_arr[0])), "pop did not return the head")

endmodule

`default_nettype wire

// ===== hdl/spq_cell.sv =====
// One slot of the sorted queue: holds an entry, shifts left or right with its neighbors.
`default_nettype none

module spq_cell (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire spq_pkg::spq_ctrl_t             ctrl_i,
  input  wire logic                           left_keep_i,
  input  wire logic                           left_occ_i,
  input  wire logic [spq_pkg::PRIO_W-1:0]     left_prio_i,
  input  wire logic [spq_pkg::ID_W-1:0]       left_id_i,
  input  wire logic                           right_occ_i,
  input  wire logic [spq_pkg::PRIO_W-1:0]     right_prio_i,
  input  wire logic [spq_pkg::ID_W-1:0]       right_id_i,
  output logic                                keep_o,
  output logic                                occ_o,
  output logic [spq_pkg::PRIO_W-1:0]          prio_o,
  output logic [spq_pkg::ID_W-1:0]            id_o
);

  logic                       occ_q, occ_d;
  logic [spq_pkg::PRIO_W-1:0] prio_q, prio_d;
  logic [spq_pkg::ID_W-1:0]   id_q, id_d;

  // Entry stays put on a push when it ranks at or ahead of the new one.
  assign keep_o = occ_q && (prio_q <= ctrl_i.prio);

  always_comb begin
    occ_d  = occ_q;
    prio_d = prio_q;
    id_d   = id_q;
    if (ctrl_i.push) begin
      if (!keep_o) begin
        if (left_keep_i) begin
          // insertion point: take the new entry
          occ_d  = 1'b1;
          prio_d = ctrl_i.prio;
          id_d   = ctrl_i.id;
        end else begin
          // behind the insertion point: shift one slot toward the tail
          occ_d  = left_occ_i;
          prio_d = left_prio_i;
          id_d   = left_id_i;
        end
      end
    end else if (ctrl_i.pop) begin
      occ_d  = right_occ_i;
      prio_d = right_prio_i;
      id_d   = right_id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    id_q   <= id_d;
  end

  assign occ_o  = occ_q;
  assign prio_o = prio_q;
  assign id_o   = id_q;

endmodule

`default_nettype wire
